>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the limiter RTL. They expect clk and rst_n in
// the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define PACL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PACL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PACL_ASSERT_IMPL(label, ante, cons, msg)
`define PACL_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> hw/rtl/pacl_pkg.sv
// ----------------------------------------------------------------------------
// pacl_pkg
// Types and constants of the per-address connection limiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pacl_pkg;

  localparam int CLIENTS         = 256;
  localparam int ADDRESS_ENTRIES = 64;

  localparam int SLOT_W    = $clog2(CLIENTS);
  localparam int ENT_W     = $clog2(ADDRESS_ENTRIES);
  localparam int IN_SLOT_W = 9;
  localparam int IP_W      = 32;
  localparam int CNT_W     = 16;

  localparam int CLR_DEPTH = (CLIENTS > ADDRESS_ENTRIES) ? CLIENTS : ADDRESS_ENTRIES;
  localparam int CLR_W     = $clog2(CLR_DEPTH);

  localparam logic [CNT_W-1:0] CNT_MAX       = '1;
  localparam logic [CNT_W-1:0] MAX_PER_RESET = 16'd2;

  // Operation codes
  localparam logic OP_LOGIN      = 1'b0;
  localparam logic OP_DISCONNECT = 1'b1;

  // Configuration registers
  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-1:0] REG_MAX_PER_ADDRESS = 3'd0;

  typedef struct packed {
    logic                 operation;
    logic [IN_SLOT_W-1:0] client_slot;
    logic [IP_W-1:0]      peer_address;
    logic                 address_known;
    logic                 exempt;
  } in_item_t;

  typedef struct packed {
    logic             kick;
    logic [CNT_W-1:0] address_count;
    logic             table_full;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    logic [ENT_W-1:0] entry;
  } bind_rec_t;

  typedef struct packed {
    logic             valid;
    logic [IP_W-1:0]  addr;
    logic [CNT_W-1:0] count;
  } addr_rec_t;

  localparam int BIND_W = $bits(bind_rec_t);
  localparam int REC_W  = $bits(addr_rec_t);

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [ENT_W-1:0] hit_idx;
    logic [CNT_W-1:0] hit_count;
    logic             free;
    logic [ENT_W-1:0] free_idx;
  } scan_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/pacl_ram.sv
// ----------------------------------------------------------------------------
// pacl_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/pacl_scan.sv
// ----------------------------------------------------------------------------
// pacl_scan
// Address table search: streams every entry through the read port and keeps
// the first entry matching the key and the lowest free entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pacl_scan
  import pacl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [IP_W-1:0]  key,
  input  wire addr_rec_t        rdata,
  output logic      [ENT_W-1:0] raddr,
  output scan_res_t             res
);

  localparam logic [ENT_W:0] LAST_CNT = (ENT_W+1)'(ADDRESS_ENTRIES);

  logic [ENT_W:0]   rd_cnt_r;
  logic             busy_r;
  logic             dv_r;
  logic [ENT_W-1:0] didx_r;
  logic             hit_r;
  logic [ENT_W-1:0] hit_idx_r;
  logic [CNT_W-1:0] hit_cnt_r;
  logic             free_r;
  logic [ENT_W-1:0] free_idx_r;
  logic             issue;

  assign issue = busy_r && (rd_cnt_r != LAST_CNT);
  assign raddr = rd_cnt_r[ENT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      dv_r   <= 1'b0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      dv_r   <= 1'b0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else begin
      dv_r <= issue;
      if (res.done) begin
        busy_r <= 1'b0;
      end
      if (dv_r) begin
        if (rdata.valid) begin
          if (!hit_r && rdata.addr == key) begin
            hit_r <= 1'b1;
          end
        end else if (!free_r) begin
          free_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rd_cnt_r <= '0;
    end else if (issue) begin
      rd_cnt_r <= rd_cnt_r + (ENT_W+1)'(1);
    end
    didx_r <= rd_cnt_r[ENT_W-1:0];
    if (dv_r && rdata.valid && !hit_r && rdata.addr == key) begin
      hit_idx_r <= didx_r;
      hit_cnt_r <= rdata.count;
    end
    if (dv_r && !rdata.valid && !free_r) begin
      free_idx_r <= didx_r;
    end
  end

  // Results are final once every issued read has come back.
  assign res.done      = busy_r && (rd_cnt_r == LAST_CNT) && !dv_r;
  assign res.hit       = hit_r;
  assign res.hit_idx   = hit_idx_r;
  assign res.hit_count = hit_cnt_r;
  assign res.free      = free_r;
  assign res.free_idx  = free_idx_r;

endmodule

`default_nettype wire

>>> hw/rtl/per_address_connection_limiter_top.sv
// ----------------------------------------------------------------------------
// per_address_connection_limiter_top
// Limits parallel connections per IPv4 address. Slot bindings and address
// counters live in two RAMs. A disconnect reads the slot binding, then the
// counter entry, and writes both back. A login searches the whole address
// table through its single read port, one entry per cycle. One item is in
// work at a time; the result waits in an output register while the next
// item is accepted. After reset a clearing pass zeroes both RAMs, and no
// item is accepted until it is done; configuration writes are taken
// throughout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module per_address_connection_limiter_top
  import pacl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_item_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_item_t               out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_BIND  = 6'b000100,
    S_ENTRY = 6'b001000,
    S_SCAN  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  localparam int SLOT_EXT_W = (SLOT_W > IN_SLOT_W) ? SLOT_W : IN_SLOT_W;

  state_t            state_r, state_nxt;
  logic [CLR_W-1:0]  clr_r;
  logic [CNT_W-1:0]  max_r;
  logic [SLOT_W-1:0] slot_r;
  logic [IP_W-1:0]   key_r;
  logic [ENT_W-1:0]  ent_idx_r;
  out_item_t         res_r, res_nxt;
  out_item_t         out_r;
  logic              out_valid_r;

  logic              in_xfer;
  logic              slot_ok;
  logic [SLOT_EXT_W-1:0] slot_ext;
  logic [SLOT_W-1:0] slot_idx;
  logic              load_out;
  logic              scan_start;
  scan_res_t         scan_res;
  logic [ENT_W-1:0]  scan_raddr;

  logic              bind_we;
  logic [SLOT_W-1:0] bind_waddr;
  bind_rec_t         bind_wdata;
  logic [BIND_W-1:0] bind_rdata;
  bind_rec_t         bind_rd;

  logic              ent_we;
  logic [ENT_W-1:0]  ent_waddr;
  addr_rec_t         ent_wdata;
  logic [ENT_W-1:0]  ent_raddr;
  logic [REC_W-1:0]  ent_rdata;
  addr_rec_t         ent_rd;

  logic [CNT_W-1:0]  login_cnt;
  logic [CNT_W-1:0]  dec_cnt;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == REG_MAX_PER_ADDRESS) ? 32'(max_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_PER_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_MAX_PER_ADDRESS) begin
      max_r <= pwdata[CNT_W-1:0];
    end
  end

  // Input decode
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign slot_ext = SLOT_EXT_W'(in_data.client_slot) - SLOT_EXT_W'(1);
  assign slot_idx = slot_ext[SLOT_W-1:0];
  assign slot_ok  = (in_data.client_slot != '0) &&
                    (32'(in_data.client_slot) <= 32'(CLIENTS));

  assign bind_rd = bind_rec_t'(bind_rdata);
  assign ent_rd  = addr_rec_t'(ent_rdata);

  // Only the disconnect path reads the address table outside the search.
  assign ent_raddr = (state_r == S_BIND) ? bind_rd.entry : scan_raddr;

  assign login_cnt = scan_res.hit ?
                     ((scan_res.hit_count == CNT_MAX) ? scan_res.hit_count
                                                      : scan_res.hit_count + CNT_W'(1))
                     : CNT_W'(1);
  assign dec_cnt   = (ent_rd.count != '0) ? ent_rd.count - CNT_W'(1) : '0;

  always_comb begin
    state_nxt  = state_r;
    res_nxt    = res_r;
    load_out   = 1'b0;
    scan_start = 1'b0;
    bind_we    = 1'b0;
    bind_waddr = slot_r;
    bind_wdata = '0;
    ent_we     = 1'b0;
    ent_waddr  = ent_idx_r;
    ent_wdata  = '0;
    case (state_r)
      S_CLEAR: begin
        bind_we    = (32'(clr_r) < 32'(CLIENTS));
        bind_waddr = clr_r[SLOT_W-1:0];
        ent_we     = (32'(clr_r) < 32'(ADDRESS_ENTRIES));
        ent_waddr  = clr_r[ENT_W-1:0];
        if (clr_r == CLR_W'(CLR_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          res_nxt = '0;
          if (!slot_ok) begin
            state_nxt = S_DONE;
          end else if (in_data.operation == OP_DISCONNECT) begin
            state_nxt = S_BIND;
          end else if (!in_data.address_known) begin
            res_nxt.kick = 1'b1;
            state_nxt    = S_DONE;
          end else if (in_data.exempt) begin
            state_nxt = S_DONE;
          end else begin
            scan_start = 1'b1;
            state_nxt  = S_SCAN;
          end
        end
      end
      S_BIND: begin
        // Drop the binding; fetch the counter if it still points somewhere.
        bind_we = 1'b1;
        if (bind_rd.valid && (32'(bind_rd.entry) < 32'(ADDRESS_ENTRIES))) begin
          state_nxt = S_ENTRY;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_ENTRY: begin
        if (ent_rd.valid) begin
          ent_we = 1'b1;
          if (dec_cnt != '0) begin
            ent_wdata.valid = 1'b1;
            ent_wdata.addr  = ent_rd.addr;
            ent_wdata.count = dec_cnt;
          end
          res_nxt.address_count = dec_cnt;
        end
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        if (scan_res.done) begin
          state_nxt = S_DONE;
          bind_we   = 1'b1;
          if (scan_res.hit || scan_res.free) begin
            ent_we           = 1'b1;
            ent_waddr        = scan_res.hit ? scan_res.hit_idx : scan_res.free_idx;
            ent_wdata.valid  = 1'b1;
            ent_wdata.addr   = key_r;
            ent_wdata.count  = login_cnt;
            bind_wdata.valid = 1'b1;
            bind_wdata.entry = ent_waddr;
            res_nxt.kick          = (login_cnt > max_r);
            res_nxt.address_count = login_cnt;
          end else begin
            res_nxt.kick       = 1'b1;
            res_nxt.table_full = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + CLR_W'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (in_xfer) begin
      slot_r <= slot_idx;
      key_r  <= in_data.peer_address;
    end
    if (state_r == S_BIND) begin
      ent_idx_r <= bind_rd.entry;
    end
    if (load_out) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  pacl_ram #(
    .WIDTH(BIND_W),
    .DEPTH(CLIENTS)
  ) u_bind_ram (
    .clk  (clk),
    .we   (bind_we),
    .waddr(bind_waddr),
    .wdata(bind_wdata),
    .raddr(slot_idx),
    .rdata(bind_rdata)
  );

  pacl_ram #(
    .WIDTH(REC_W),
    .DEPTH(ADDRESS_ENTRIES)
  ) u_addr_ram (
    .clk  (clk),
    .we   (ent_we),
    .waddr(ent_waddr),
    .wdata(ent_wdata),
    .raddr(ent_raddr),
    .rdata(ent_rdata)
  );

  pacl_scan u_scan (
    .clk  (clk),
    .rst_n(rst_n),
    .start(scan_start),
    .key  (key_r),
    .rdata(ent_rd),
    .raddr(scan_raddr),
    .res  (scan_res)
  );

  `PACL_ASSERT_IMPL(a_full_kicks, out_valid_r && out_r.table_full, out_r.kick && out_r.address_count == '0, "table full result without kick or with nonzero count")
  `PACL_ASSERT_IMPL(a_kick_over_limit, out_valid_r && out_r.kick && out_r.address_count != '0, out_r.address_count > max_r, "kick with count within limit")
  `PACL_ASSERT_NEXT(a_one_in_work, in_valid && in_ready, !in_ready, "second item accepted while one is in work")

endmodule

`default_nettype wire

>>> tb/per_address_connection_limiter_top_test.sv
// ----------------------------------------------------------------------------
// per_address_connection_limiter_top_test
// Self-checking bench for the per-address connection limiter. A predictor
// keeps its own slot bindings and address counters and works out the result
// of every accepted event. A checker compares each result transfer with the
// oldest predicted result. Directed events, a table-full pass and random
// traffic over several limit settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_address_connection_limiter_top_test;
  import pacl_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  per_address_connection_limiter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted limiter state
  logic [CNT_W-1:0] max_limit = MAX_PER_RESET;
  logic             slot_bound [CLIENTS];
  logic [ENT_W-1:0] slot_entry [CLIENTS];
  logic             ent_valid  [ADDRESS_ENTRIES];
  logic [IP_W-1:0]  ent_addr   [ADDRESS_ENTRIES];
  logic [CNT_W-1:0] ent_count  [ADDRESS_ENTRIES];

  out_item_t pending_results[$];
  int        mismatches = 0;
  int        events_sent = 0;
  int        results_checked = 0;
  int        kicks_seen = 0;
  int        full_seen = 0;
  int        limits_used = 0;
  bit        no_idle = 1'b0;

  initial begin
    for (int i = 0; i < CLIENTS; i++) begin
      slot_bound[i] = 1'b0;
      slot_entry[i] = '0;
    end
    for (int i = 0; i < ADDRESS_ENTRIES; i++) begin
      ent_valid[i] = 1'b0;
      ent_addr[i]  = '0;
      ent_count[i] = '0;
    end
  end

  function automatic out_item_t predict_limiter(in_item_t it);
    out_item_t r;
    int        s;
    int        e;
    int        hit;
    int        free_idx;
    r = '0;
    if (it.client_slot < 1 || it.client_slot > CLIENTS) return r;
    s = it.client_slot - 1;
    if (it.operation == OP_DISCONNECT) begin
      if (slot_bound[s] && ent_valid[slot_entry[s]]) begin
        e = int'(slot_entry[s]);
        if (ent_count[e] != 0) ent_count[e] = ent_count[e] - CNT_W'(1);
        r.address_count = ent_count[e];
        if (ent_count[e] == 0) begin
          ent_valid[e] = 1'b0;
          ent_addr[e]  = '0;
        end
      end
      slot_bound[s] = 1'b0;
      slot_entry[s] = '0;
    end else if (!it.address_known) begin
      r.kick = 1'b1;
    end else if (!it.exempt) begin
      hit = -1;
      free_idx = -1;
      for (int i = 0; i < ADDRESS_ENTRIES; i++) begin
        if (ent_valid[i]) begin
          if (hit < 0 && ent_addr[i] == it.peer_address) hit = i;
        end else if (free_idx < 0) begin
          free_idx = i;
        end
      end
      if (hit < 0) begin
        if (free_idx < 0) begin
          slot_bound[s] = 1'b0;
          slot_entry[s] = '0;
          r.kick = 1'b1;
          r.table_full = 1'b1;
          return r;
        end
        hit = free_idx;
        ent_valid[hit] = 1'b1;
        ent_addr[hit]  = it.peer_address;
        ent_count[hit] = '0;
      end
      if (ent_count[hit] != CNT_MAX) ent_count[hit] = ent_count[hit] + CNT_W'(1);
      slot_bound[s] = 1'b1;
      slot_entry[s] = ENT_W'(hit);
      r.kick = (ent_count[hit] > max_limit);
      r.address_count = ent_count[hit];
    end
    return r;
  endfunction

  function automatic int free_entries();
    int n;
    n = 0;
    for (int i = 0; i < ADDRESS_ENTRIES; i++) if (!ent_valid[i]) n++;
    return n;
  endfunction

  function automatic in_item_t make_event(logic op, int slot, logic [IP_W-1:0] addr,
                                          logic known, logic exempt);
    in_item_t it;
    it.operation     = op;
    it.client_slot   = IN_SLOT_W'(slot);
    it.peer_address  = addr;
    it.address_known = known;
    it.exempt        = exempt;
    return it;
  endfunction

  // Random slot, preferring one whose bound state matches want_bound.
  function automatic int pick_slot(bit want_bound);
    int s;
    s = 1;
    for (int k = 0; k < 8; k++) begin
      s = $urandom_range(1, CLIENTS);
      if (slot_bound[s-1] == want_bound) return s;
    end
    return s;
  endfunction

  // Entered and left just after a falling edge.
  task automatic send_event(in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_results.push_back(predict_limiter(it));
    events_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_read_check(logic [PADDR_W-1:0] a, logic [CNT_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= a;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata[CNT_W-1:0] !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register readback mismatch at %0h: expected %0d, got %0d",
                 a, want, prdata[CNT_W-1:0]);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_limit(logic [CNT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_MAX_PER_ADDRESS;
    pwdata  <= {16'b0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    max_limit = value;
    limits_used++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    cfg_read_check(REG_MAX_PER_ADDRESS, value);
  endtask

  // Result channel: random stall before each transfer.
  initial begin
    int k;
    forever begin
      k = no_idle ? 0 : $urandom_range(0, 19);
      if (k > 0) begin
        out_ready <= 1'b0;
        repeat (k) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1 || !rst_n);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      results_checked++;
      if (out_data.kick === 1'b1) kicks_seen++;
      if (out_data.table_full === 1'b1) full_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: kick %b count %0d full %b",
                   out_data.kick, out_data.address_count, out_data.table_full);
      end else begin
        want = pending_results.pop_front();
        if (out_data.kick !== want.kick || out_data.address_count !== want.address_count ||
            out_data.table_full !== want.table_full) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected kick %b count %0d full %b, got kick %b count %0d full %b",
                     want.kick, want.address_count, want.table_full,
                     out_data.kick, out_data.address_count, out_data.table_full);
        end
      end
    end
  end

  task automatic test_reset_value();
    cfg_read_check(REG_MAX_PER_ADDRESS, MAX_PER_RESET);
  endtask

  task automatic test_directed();
    // out-of-range slots
    send_event(make_event(OP_LOGIN, 0, 32'h0A00_0001, 1'b1, 1'b0));
    send_event(make_event(OP_DISCONNECT, 0, 32'h0, 1'b0, 1'b0));
    send_event(make_event(OP_LOGIN, 257, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send_event(make_event(OP_DISCONNECT, 511, 32'hFFFF_FFFF, 1'b1, 1'b1));
    // unknown address, and unknown takes precedence over exempt
    send_event(make_event(OP_LOGIN, 1, 32'h0, 1'b0, 1'b0));
    send_event(make_event(OP_LOGIN, 4, 32'hFFFF_FFFF, 1'b0, 1'b1));
    send_event(make_event(OP_LOGIN, 1, 32'hC0A8_0001, 1'b1, 1'b1));
    // three logins from one address: the third goes over the limit
    send_event(make_event(OP_LOGIN, 1, 32'h0, 1'b1, 1'b0));
    send_event(make_event(OP_LOGIN, 2, 32'h0, 1'b1, 1'b0));
    send_event(make_event(OP_LOGIN, 3, 32'h0, 1'b1, 1'b0));
    send_event(make_event(OP_LOGIN, 256, 32'hFFFF_FFFF, 1'b1, 1'b0));
    send_event(make_event(OP_DISCONNECT, 5, 32'h0, 1'b1, 1'b0));
    send_event(make_event(OP_DISCONNECT, 3, 32'hFFFF_FFFF, 1'b0, 1'b1));
    // rebind a slot; the old address keeps its count
    send_event(make_event(OP_LOGIN, 1, 32'h1234_5678, 1'b1, 1'b0));
    send_event(make_event(OP_DISCONNECT, 1, 32'h0, 1'b1, 1'b0));
    send_event(make_event(OP_DISCONNECT, 1, 32'h0, 1'b1, 1'b0));
    send_event(make_event(OP_LOGIN, 2, 32'h5555_AAAA, 1'b1, 1'b1));
    send_event(make_event(OP_DISCONNECT, 2, 32'h0, 1'b1, 1'b0));
    send_event(make_event(OP_DISCONNECT, 256, 32'h0, 1'b1, 1'b0));
    wait_idle();
    set_limit(16'd0);
    send_event(make_event(OP_LOGIN, 10, 32'hAAAA_5555, 1'b1, 1'b0));
    send_event(make_event(OP_DISCONNECT, 10, 32'h0, 1'b1, 1'b0));
    wait_idle();
  endtask

  task automatic test_table_full();
    int s;
    set_limit(16'd1);
    while (free_entries() > 0)
      send_event(make_event(OP_LOGIN, pick_slot(1'b0), $urandom, 1'b1, 1'b0));
    repeat (3)
      send_event(make_event(OP_LOGIN, pick_slot(1'b0), $urandom, 1'b1, 1'b0));
    // full table on a bound slot drops its binding
    send_event(make_event(OP_LOGIN, pick_slot(1'b1), $urandom, 1'b1, 1'b0));
    // an address already in the table still gets counted
    s = pick_slot(1'b1);
    send_event(make_event(OP_LOGIN, pick_slot(1'b0), ent_addr[slot_entry[s-1]], 1'b1, 1'b0));
    for (int i = 1; i <= CLIENTS; i++)
      if (slot_bound[i-1]) send_event(make_event(OP_DISCONNECT, i, $urandom, 1'b1, 1'b0));
    wait_idle();
  endtask

  task automatic test_random();
    logic [CNT_W-1:0] limits [5];
    logic [IP_W-1:0]  pool [12];
    in_item_t         it;
    int               r;
    limits[0] = 16'd0;
    limits[1] = 16'd1;
    limits[2] = 16'd3;
    limits[3] = 16'hFFFF;
    limits[4] = CNT_W'($urandom_range(4, 12));
    for (int p = 0; p < 5; p++) begin
      set_limit(limits[p]);
      foreach (pool[i]) pool[i] = $urandom;
      for (int n = 0; n < 350; n++) begin
        if (n % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
        // hold off until every result is back, once per phase
        if (n == 175) wait_idle();
        r = $urandom_range(0, 99);
        if (r < 45) begin
          it = make_event(OP_LOGIN, pick_slot(1'b0),
                          ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, 11)],
                          1'b1, 1'b0);
        end else if (r < 80) begin
          it = make_event(OP_DISCONNECT, pick_slot(1'b1), $urandom,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else if (r < 86) begin
          it = make_event(OP_LOGIN, $urandom_range(1, CLIENTS), $urandom,
                          1'b0, 1'($urandom_range(0, 1)));
        end else if (r < 91) begin
          it = make_event(OP_LOGIN, $urandom_range(1, CLIENTS), pool[$urandom_range(0, 11)],
                          1'b1, 1'b1);
        end else if (r < 96) begin
          it = make_event(1'($urandom_range(0, 1)),
                          ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(CLIENTS + 1, 511),
                          $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          it = make_event(OP_LOGIN, pick_slot(1'b1), pool[$urandom_range(0, 11)], 1'b1, 1'b0);
        end
        send_event(it);
      end
      no_idle = 1'b0;
      wait_idle();
    end
  endtask

  initial begin
    int guard;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_value();
    test_directed();
    test_table_full();
    test_random();
    in_valid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) mismatches += pending_results.size();
    $display("Sent %0d login/disconnect events over %0d limit settings; %0d results checked",
             events_sent, limits_used + 1, results_checked);
    $display("Results with kick: %0d, with table full: %0d, mismatches: %0d",
             kicks_seen, full_seen, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
